// ===== hw/rtl/smr_pkg.sv =====
// Shared types and constants for the SPI mode 3 register master.
package smr_pkg;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_STREAM = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_HALF_PERIOD = 2'd0,
		REG_LEAD_DELAY  = 2'd1,
		REG_TAIL_DELAY  = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	localparam logic [7:0] WRITE_FLAG        = 8'h80;
	localparam logic [7:0] HALF_PERIOD_RESET = 8'd8;
	localparam logic [7:0] LEAD_DELAY_RESET  = 8'd16;
	localparam logic [7:0] TAIL_DELAY_RESET  = 8'd8;

	// One tick as it leaves the front end.
	typedef struct packed {
		logic       start_ok;
		op_t        op;
		logic       chip_sel;
		logic [6:0] reg_addr;
		logic [7:0] write_data;
		logic [7:0] byte_count;
		logic       miso;
	} cmd_t;

	typedef struct packed {
		logic [7:0] half_period;
		logic [7:0] lead_delay;
		logic [7:0] tail_delay;
	} cfg_t;

	typedef struct packed {
		logic       sck;
		logic       mosi;
		logic       cs_sensor_n;
		logic       cs_flash_n;
		logic       busy_res;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       done_res;
	} res_t;

endpackage

// ===== hw/rtl/smr_regs.sv =====
// APB configuration registers: half period, lead delay, tail delay.
module smr_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output smr_pkg::cfg_t cfg
);

	smr_pkg::cfg_t    cfg_q;
	smr_pkg::reg_idx_t idx;

	assign idx    = smr_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= smr_pkg::HALF_PERIOD_RESET;
			cfg_q.lead_delay  <= smr_pkg::LEAD_DELAY_RESET;
			cfg_q.tail_delay  <= smr_pkg::TAIL_DELAY_RESET;
		end else if (psel && penable && pwrite) begin
			case (idx)
				smr_pkg::REG_HALF_PERIOD: cfg_q.half_period <= pwdata[7:0];
				smr_pkg::REG_LEAD_DELAY:  cfg_q.lead_delay  <= pwdata[7:0];
				smr_pkg::REG_TAIL_DELAY:  cfg_q.tail_delay  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			smr_pkg::REG_HALF_PERIOD: prdata = {24'd0, cfg_q.half_period};
			smr_pkg::REG_LEAD_DELAY:  prdata = {24'd0, cfg_q.lead_delay};
			smr_pkg::REG_TAIL_DELAY:  prdata = {24'd0, cfg_q.tail_delay};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

// ===== hw/rtl/smr_front.sv =====
// Front end: accept ticks, classify the command, queue them for the engine.
module smr_front #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          start_req,
	input  logic [1:0]    func,
	input  logic          chip_sel,
	input  logic [6:0]    reg_addr,
	input  logic [7:0]    write_data,
	input  logic [7:0]    byte_count,
	input  logic          miso,
	output smr_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_pop
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	smr_pkg::cmd_t  queue_q [DEPTH];
	smr_pkg::cmd_t  cmd_in;
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	// Drop requests with an unknown function code here.
	always_comb begin
		cmd_in.start_ok   = start_req && (func != smr_pkg::OP_NONE);
		cmd_in.op         = smr_pkg::op_t'(func);
		cmd_in.chip_sel   = chip_sel;
		cmd_in.reg_addr   = reg_addr;
		cmd_in.write_data = write_data;
		cmd_in.byte_count = byte_count;
		cmd_in.miso       = miso;
	end

	assign in_ready  = (count_q != FULL);
	assign cmd_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/smr_engine.sv =====
// Back end: SPI mode 3 bit engine, one tick per queued word, registered result.
module smr_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  smr_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  smr_pkg::cfg_t cfg,
	output smr_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_ready
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SETUP = 3'd1,
		PH_LEAD  = 3'd2,
		PH_LOW   = 3'd3,
		PH_HIGH  = 3'd4,
		PH_TAIL  = 3'd5
	} phase_t;

	phase_t        phase_q, phase_n;
	logic [7:0]    tick_q, tick_n;
	logic [2:0]    bit_q, bit_n;
	logic [7:0]    tx_q, tx_n;
	logic [7:0]    rx_q, rx_n;
	logic [7:0]    left_q, left_n;
	smr_pkg::op_t  op_q, op_n;
	logic          chip_q, chip_n;
	logic          addr_q, addr_n;
	smr_pkg::res_t res_q, res_n;
	logic          res_valid_q;
	logic          step;

	assign step      = cmd_valid && (!res_valid_q || res_ready);
	assign cmd_pop   = step;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_comb begin
		logic [7:0] hp;
		logic [7:0] tick_inc;
		logic       hit;
		logic       receiving;
		logic       cs_low;
		logic       finish;

		hp        = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
		phase_n   = phase_q;
		tick_n    = tick_q;
		bit_n     = bit_q;
		tx_n      = tx_q;
		rx_n      = rx_q;
		left_n    = left_q;
		op_n      = op_q;
		chip_n    = chip_q;
		addr_n    = addr_q;
		cs_low    = 1'b0;
		finish    = 1'b0;
		hit       = 1'b0;
		res_n.sck      = 1'b1;
		res_n.mosi     = 1'b1;
		res_n.busy_res = 1'b1;
		res_n.rx_valid = 1'b0;
		res_n.rx_data  = 8'd0;
		res_n.done_res = 1'b0;

		// Load a new transaction.
		if (phase_q == PH_IDLE && cmd.start_ok) begin
			op_n   = cmd.op;
			chip_n = cmd.chip_sel;
			addr_n = 1'b1;
			bit_n  = 3'd7;
			tick_n = 8'd0;
			tx_n   = {1'b0, cmd.reg_addr};
			rx_n   = 8'd0;
			left_n = 8'd0;
			if (cmd.op == smr_pkg::OP_WRITE) begin
				tx_n = {1'b0, cmd.reg_addr} | smr_pkg::WRITE_FLAG;
				rx_n = cmd.write_data;
			end else if (cmd.op == smr_pkg::OP_STREAM) begin
				left_n = cmd.byte_count;
			end
			phase_n = (cmd.op == smr_pkg::OP_STREAM) ? PH_LOW : PH_SETUP;
		end

		receiving = !addr_n && (op_n != smr_pkg::OP_WRITE);
		tick_inc  = tick_n + 8'd1;

		case (phase_n)
			PH_SETUP: begin
				tick_n  = 8'd0;
				phase_n = (cfg.lead_delay == 8'd0) ? PH_LOW : PH_LEAD;
			end
			PH_LEAD: begin
				cs_low = 1'b1;
				hit    = (tick_inc >= cfg.lead_delay);
				tick_n = hit ? 8'd0 : tick_inc;
				if (hit) begin
					phase_n = PH_LOW;
				end
			end
			PH_LOW: begin
				cs_low     = 1'b1;
				res_n.sck  = 1'b0;
				res_n.mosi = receiving ? 1'b1 : tx_n[7];
				hit        = (tick_inc >= hp);
				tick_n     = hit ? 8'd0 : tick_inc;
				if (hit) begin
					// Sample MISO on the last low tick.
					if (receiving) begin
						rx_n = {rx_n[6:0], cmd.miso};
						if (bit_n == 3'd0) begin
							res_n.rx_valid = 1'b1;
							res_n.rx_data  = {rx_n[7:1], cmd.miso};
						end
					end
					phase_n = PH_HIGH;
				end
			end
			PH_HIGH: begin
				cs_low     = 1'b1;
				res_n.mosi = receiving ? 1'b1 : tx_n[7];
				hit        = (tick_inc >= hp);
				tick_n     = hit ? 8'd0 : tick_inc;
				if (hit) begin
					tx_n    = {tx_n[6:0], 1'b0};
					phase_n = PH_LOW;
					if (bit_n != 3'd0) begin
						bit_n = bit_n - 3'd1;
					end else begin
						bit_n = 3'd7;
						if (addr_n) begin
							addr_n = 1'b0;
							if (op_n == smr_pkg::OP_WRITE) begin
								tx_n = rx_n;
							end else if (op_n == smr_pkg::OP_READ) begin
								left_n = 8'd1;
							end else if (left_n == 8'd0) begin
								finish = 1'b1;
							end
						end else if (op_n == smr_pkg::OP_WRITE) begin
							finish = 1'b1;
						end else begin
							left_n = left_n - 8'd1;
							if (left_n == 8'd0) begin
								finish = 1'b1;
							end
						end
					end
					if (finish) begin
						if (op_n == smr_pkg::OP_STREAM && cfg.tail_delay != 8'd0) begin
							phase_n = PH_TAIL;
							tick_n  = 8'd0;
						end else begin
							phase_n        = PH_IDLE;
							res_n.done_res = 1'b1;
						end
					end
				end
			end
			PH_TAIL: begin
				hit    = (tick_inc >= cfg.tail_delay);
				tick_n = hit ? 8'd0 : tick_inc;
				if (hit) begin
					phase_n        = PH_IDLE;
					res_n.done_res = 1'b1;
				end
			end
			default: begin
				res_n.busy_res = 1'b0;
				phase_n        = PH_IDLE;
			end
		endcase

		res_n.cs_sensor_n = !(cs_low && !chip_n);
		res_n.cs_flash_n  = !(cs_low && chip_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= 8'd0;
			bit_q       <= 3'd7;
			tx_q        <= 8'd0;
			rx_q        <= 8'd0;
			left_q      <= 8'd0;
			op_q        <= smr_pkg::OP_READ;
			chip_q      <= 1'b0;
			addr_q      <= 1'b0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_n;
				tick_q  <= tick_n;
				bit_q   <= bit_n;
				tx_q    <= tx_n;
				rx_q    <= rx_n;
				left_q  <= left_n;
				op_q    <= op_n;
				chip_q  <= chip_n;
				addr_q  <= addr_n;
				res_q   <= res_n;
			end
			if (step) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/spi_mode3_register_master_top.sv =====
// Top level of the SPI mode 3 register master.
//
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | start_req func chip_sel reg_addr
//          |                       | write_data byte_count miso
//  out     | out_valid / out_ready | sck mosi cs_sensor_n cs_flash_n busy_res
//          |                       | rx_valid rx_data done_res
//  cfg     | APB psel/penable      | half_period lead_delay tail_delay
//
// One input word per cycle in, one result word per cycle out while out_ready
// stays high; each word is one system tick of the SPI engine, which steps
// once per word. Each word passes through the front queue and then the
// result register. A stalled output holds the engine; the queue of
// QUEUE_DEPTH words then fills and in_ready drops. Reset clears the engine
// to idle and the registers to their defaults.
module spi_mode3_register_master_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_req,
	input  logic [1:0]  func,
	input  logic        chip_sel,
	input  logic [6:0]  reg_addr,
	input  logic [7:0]  write_data,
	input  logic [7:0]  byte_count,
	input  logic        miso,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        sck,
	output logic        mosi,
	output logic        cs_sensor_n,
	output logic        cs_flash_n,
	output logic        busy_res,
	output logic        rx_valid,
	output logic [7:0]  rx_data,
	output logic        done_res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	smr_pkg::cmd_t cmd;
	smr_pkg::cfg_t cfg;
	smr_pkg::res_t res;
	logic          cmd_valid;
	logic          cmd_pop;

	smr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smr_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_req  (start_req),
		.func       (func),
		.chip_sel   (chip_sel),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.byte_count (byte_count),
		.miso       (miso),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop)
	);

	smr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg),
		.res       (res),
		.res_valid (out_valid),
		.res_ready (out_ready)
	);

	assign sck         = res.sck;
	assign mosi        = res.mosi;
	assign cs_sensor_n = res.cs_sensor_n;
	assign cs_flash_n  = res.cs_flash_n;
	assign busy_res    = res.busy_res;
	assign rx_valid    = res.rx_valid;
	assign rx_data     = res.rx_data;
	assign done_res    = res.done_res;

endmodule

// ===== test/tb_spi_mode3_register_master_top.sv =====
// Testbench for the SPI mode 3 register master: predicts every tick's pin levels and checks them.
`timescale 1ns / 100ps

module tb_spi_mode3_register_master_top;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_TICKS_PER_MODE = 20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LEAD,
		ST_LOW,
		ST_HIGH,
		ST_TAIL
	} engine_phase_t;

	typedef struct packed {
		logic          start_req;
		smr_pkg::op_t  func;
		logic          chip_sel;
		logic [6:0]    reg_addr;
		logic [7:0]    write_data;
		logic [7:0]    byte_count;
		logic          miso;
	} tick_in_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        start_req = 1'b0;
	logic [1:0]  func = 2'd0;
	logic        chip_sel = 1'b0;
	logic [6:0]  reg_addr = 7'd0;
	logic [7:0]  write_data = 8'd0;
	logic [7:0]  byte_count = 8'd0;
	logic        miso = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        sck;
	logic        mosi;
	logic        cs_sensor_n;
	logic        cs_flash_n;
	logic        busy_res;
	logic        rx_valid;
	logic [7:0]  rx_data;
	logic        done_res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	spi_mode3_register_master_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_req   (start_req),
		.func        (func),
		.chip_sel    (chip_sel),
		.reg_addr    (reg_addr),
		.write_data  (write_data),
		.byte_count  (byte_count),
		.miso        (miso),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sck         (sck),
		.mosi        (mosi),
		.cs_sensor_n (cs_sensor_n),
		.cs_flash_n  (cs_flash_n),
		.busy_res    (busy_res),
		.rx_valid    (rx_valid),
		.rx_data     (rx_data),
		.done_res    (done_res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Predicted engine state and register copies.
	engine_phase_t eng_phase = ST_IDLE;
	logic [7:0]   tick_cnt = 8'd0;
	logic [2:0]   bit_idx = 3'd7;
	logic [7:0]   tx_byte = 8'd0;
	logic [7:0]   rx_byte = 8'd0;
	logic [7:0]   bytes_left = 8'd0;
	smr_pkg::op_t eng_op = smr_pkg::OP_READ;
	logic         eng_chip = 1'b0;
	logic         addr_phase = 1'b0;
	logic [7:0]   cfg_half = smr_pkg::HALF_PERIOD_RESET;
	logic [7:0]   cfg_lead = smr_pkg::LEAD_DELAY_RESET;
	logic [7:0]   cfg_tail = smr_pkg::TAIL_DELAY_RESET;

	smr_pkg::res_t tick_levels_q [$];
	int   err_count = 0;
	int   results_seen = 0;
	int   ticks_sent = 0;
	int   quiet_cycles = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR: %s", msg);
		err_count++;
	endtask

	function automatic bit count_done(input logic [7:0] limit);
		logic [7:0] nxt;
		nxt = tick_cnt + 8'd1;
		if (nxt >= limit) begin
			tick_cnt = 8'd0;
			return 1'b1;
		end
		tick_cnt = nxt;
		return 1'b0;
	endfunction

	// Close a transfer; a stream with a tail waits it out before done.
	function automatic bit end_transfer();
		if (eng_op == smr_pkg::OP_STREAM && cfg_tail != 8'd0) begin
			eng_phase = ST_TAIL;
			tick_cnt = 8'd0;
			return 1'b0;
		end
		eng_phase = ST_IDLE;
		return 1'b1;
	endfunction

	task automatic advance_spi_engine(input tick_in_t t, output smr_pkg::res_t r);
		logic [7:0] hp;
		logic       recv;
		logic       cs_low;
		hp = (cfg_half == 8'd0) ? 8'd1 : cfg_half;
		r = '0;
		r.sck = 1'b1;
		r.mosi = 1'b1;
		r.busy_res = 1'b1;
		cs_low = 1'b0;
		if (eng_phase == ST_IDLE && t.start_req && t.func != smr_pkg::OP_NONE) begin
			eng_op = t.func;
			eng_chip = t.chip_sel;
			addr_phase = 1'b1;
			bit_idx = 3'd7;
			tick_cnt = 8'd0;
			tx_byte = {1'b0, t.reg_addr};
			rx_byte = 8'd0;
			bytes_left = 8'd0;
			if (t.func == smr_pkg::OP_WRITE) begin
				tx_byte = {1'b0, t.reg_addr} | smr_pkg::WRITE_FLAG;
				rx_byte = t.write_data;
			end else if (t.func == smr_pkg::OP_STREAM) begin
				bytes_left = t.byte_count;
			end
			eng_phase = (t.func == smr_pkg::OP_STREAM) ? ST_LOW : ST_SETUP;
		end
		recv = !addr_phase && eng_op != smr_pkg::OP_WRITE;
		case (eng_phase)
			ST_SETUP: begin
				tick_cnt = 8'd0;
				eng_phase = (cfg_lead == 8'd0) ? ST_LOW : ST_LEAD;
			end
			ST_LEAD: begin
				cs_low = 1'b1;
				if (count_done(cfg_lead))
					eng_phase = ST_LOW;
			end
			ST_LOW: begin
				cs_low = 1'b1;
				r.sck = 1'b0;
				r.mosi = recv ? 1'b1 : tx_byte[7];
				if (count_done(hp)) begin
					if (recv) begin
						rx_byte = {rx_byte[6:0], t.miso};
						if (bit_idx == 3'd0) begin
							r.rx_valid = 1'b1;
							r.rx_data = rx_byte;
						end
					end
					eng_phase = ST_HIGH;
				end
			end
			ST_HIGH: begin
				cs_low = 1'b1;
				r.mosi = recv ? 1'b1 : tx_byte[7];
				if (count_done(hp)) begin
					tx_byte = {tx_byte[6:0], 1'b0};
					eng_phase = ST_LOW;
					if (bit_idx != 3'd0) begin
						bit_idx = bit_idx - 3'd1;
					end else begin
						bit_idx = 3'd7;
						if (addr_phase) begin
							addr_phase = 1'b0;
							// Write reloads the data byte; read expects one byte back.
							if (eng_op == smr_pkg::OP_WRITE)
								tx_byte = rx_byte;
							else if (eng_op == smr_pkg::OP_READ)
								bytes_left = 8'd1;
							else if (bytes_left == 8'd0)
								r.done_res = end_transfer();
						end else if (eng_op == smr_pkg::OP_WRITE) begin
							r.done_res = end_transfer();
						end else begin
							bytes_left = bytes_left - 8'd1;
							if (bytes_left == 8'd0)
								r.done_res = end_transfer();
						end
					end
				end
			end
			ST_TAIL: begin
				if (count_done(cfg_tail)) begin
					eng_phase = ST_IDLE;
					r.done_res = 1'b1;
				end
			end
			default: begin
				r.busy_res = 1'b0;
			end
		endcase
		r.cs_sensor_n = !(cs_low && eng_chip == 1'b0);
		r.cs_flash_n = !(cs_low && eng_chip == 1'b1);
	endtask

	task automatic send_tick(input tick_in_t t);
		smr_pkg::res_t want;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= t.start_req;
		func <= t.func;
		chip_sel <= t.chip_sel;
		reg_addr <= t.reg_addr;
		write_data <= t.write_data;
		byte_count <= t.byte_count;
		miso <= t.miso;
		do @(posedge clk); while (!in_ready);
		advance_spi_engine(t, want);
		tick_levels_q.push_back(want);
		ticks_sent++;
	endtask

	function automatic tick_in_t noise_tick();
		tick_in_t t;
		t.start_req = 1'($urandom_range(0, 1));
		t.func = smr_pkg::op_t'($urandom_range(0, 3));
		t.chip_sel = 1'($urandom_range(0, 1));
		t.reg_addr = 7'($urandom_range(0, 127));
		t.write_data = 8'($urandom_range(0, 255));
		t.byte_count = 8'($urandom_range(0, 255));
		t.miso = 1'($urandom_range(0, 1));
		return t;
	endfunction

	// Keep ticking with random MISO and stray requests until the engine is idle.
	task automatic clock_out_transfer();
		while (eng_phase != ST_IDLE)
			send_tick(noise_tick());
	endtask

	task automatic run_transfer(input smr_pkg::op_t op, input logic chip,
			input logic [6:0] addr, input logic [7:0] data, input logic [7:0] count);
		tick_in_t t;
		t = noise_tick();
		t.start_req = 1'b1;
		t.func = op;
		t.chip_sel = chip;
		t.reg_addr = addr;
		t.write_data = data;
		t.byte_count = count;
		send_tick(t);
		clock_out_transfer();
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (tick_levels_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input smr_pkg::reg_idx_t idx, input logic [7:0] value);
		logic [31:0] word;
		word = $urandom;
		word[7:0] = value;
		wait_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			smr_pkg::REG_HALF_PERIOD: cfg_half = value;
			smr_pkg::REG_LEAD_DELAY:  cfg_lead = value;
			smr_pkg::REG_TAIL_DELAY:  cfg_tail = value;
			default: ;
		endcase
		if (idx == smr_pkg::REG_NONE) begin
			psel <= 1'b0;
			penable <= 1'b0;
		end else begin
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata[7:0] !== value)
				report_error($sformatf("register %s reads %h, want %h",
					idx.name(), prdata[7:0], value));
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic test_reset_values();
		tick_in_t t;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3) begin
			t = noise_tick();
			t.start_req = 1'b0;
			send_tick(t);
		end
		run_transfer(smr_pkg::OP_STREAM, 1'b0, 7'h2A, 8'h00, 8'd0);
	endtask

	task automatic test_register_ops();
		tick_in_t t;
		send_idle_pct = 6;
		recv_stall_pct = 6;
		cfg_write(smr_pkg::REG_HALF_PERIOD, 8'd1);
		cfg_write(smr_pkg::REG_LEAD_DELAY, 8'd0);
		cfg_write(smr_pkg::REG_TAIL_DELAY, 8'd0);
		run_transfer(smr_pkg::OP_READ, 1'b0, 7'h7F, 8'h00, 8'd0);
		run_transfer(smr_pkg::OP_WRITE, 1'b1, 7'h00, 8'hFF, 8'd0);
		run_transfer(smr_pkg::OP_STREAM, 1'b1, 7'h12, 8'h00, 8'd0);
		run_transfer(smr_pkg::OP_STREAM, 1'b0, 7'h6B, 8'h00, 8'd3);
		// Unknown function while idle: drop it.
		t = noise_tick();
		t.start_req = 1'b1;
		t.func = smr_pkg::OP_NONE;
		send_tick(t);
		cfg_write(smr_pkg::REG_LEAD_DELAY, 8'd2);
		cfg_write(smr_pkg::REG_TAIL_DELAY, 8'd3);
		run_transfer(smr_pkg::OP_READ, 1'b1, 7'h40, 8'h00, 8'd0);
		// Hold the sender mid-stream until every word is back.
		t = noise_tick();
		t.start_req = 1'b1;
		t.func = smr_pkg::OP_STREAM;
		t.byte_count = 8'd2;
		send_tick(t);
		repeat (5) send_tick(noise_tick());
		wait_results();
		clock_out_transfer();
	endtask

	task automatic test_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_write(smr_pkg::REG_HALF_PERIOD, 8'd0);
		cfg_write(smr_pkg::REG_LEAD_DELAY, 8'd1);
		cfg_write(smr_pkg::REG_TAIL_DELAY, 8'd255);
		cfg_write(smr_pkg::REG_NONE, 8'hFF);
		run_transfer(smr_pkg::OP_READ, 1'b1, 7'h33, 8'h00, 8'd0);
		run_transfer(smr_pkg::OP_WRITE, 1'b1, 7'h3C, 8'hA5, 8'd0);
		cfg_write(smr_pkg::REG_TAIL_DELAY, 8'd1);
		run_transfer(smr_pkg::OP_STREAM, 1'b0, 7'h4C, 8'h00, 8'd1);
	endtask

	task automatic test_random_traffic();
		int send_pct [4] = '{0, 85, 0, 6};
		int stall_pct [4] = '{0, 0, 85, 6};
		int mode_start;
		tick_in_t t;
		for (int m = 0; m < 4; m++) begin
			cfg_write(smr_pkg::REG_HALF_PERIOD, 8'($urandom_range(0, 2)));
			cfg_write(smr_pkg::REG_LEAD_DELAY, 8'($urandom_range(0, 4)));
			cfg_write(smr_pkg::REG_TAIL_DELAY, 8'($urandom_range(0, 4)));
			send_idle_pct = send_pct[m];
			recv_stall_pct = stall_pct[m];
			mode_start = ticks_sent;
			while (ticks_sent - mode_start < RANDOM_TICKS_PER_MODE) begin
				t = noise_tick();
				if ($urandom_range(0, 99) < 85) begin
					t.start_req = 1'b1;
					t.func = smr_pkg::op_t'($urandom_range(0, 2));
				end
				t.byte_count = 8'($urandom_range(0, 3));
				send_tick(t);
				clock_out_transfer();
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_error($sformatf("word %0d: %s is %h, want %h", results_seen, name, got, want));
	endtask

	always @(posedge clk) begin : pin_check
		smr_pkg::res_t got;
		smr_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {sck, mosi, cs_sensor_n, cs_flash_n, busy_res, rx_valid, rx_data, done_res};
			if (tick_levels_q.size() == 0) begin
				report_error($sformatf("word %0d arrived with nothing pending", results_seen));
			end else begin
				want = tick_levels_q.pop_front();
				check_field("sck", 8'(got.sck), 8'(want.sck));
				check_field("mosi", 8'(got.mosi), 8'(want.mosi));
				check_field("cs_sensor_n", 8'(got.cs_sensor_n), 8'(want.cs_sensor_n));
				check_field("cs_flash_n", 8'(got.cs_flash_n), 8'(want.cs_flash_n));
				check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
				check_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
				check_field("rx_data", got.rx_data, want.rx_data);
				check_field("done_res", 8'(got.done_res), 8'(want.done_res));
			end
			results_seen++;
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_register_ops();
		test_extremes();
		test_random_traffic();
		wait_results();
		repeat (6) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
